### hw/rtl/gsig_pkg.sv
// shared types and constants of the grid strip index generator
package gsig_pkg;

	localparam int unsigned MAX_SIDE_DEF = 256;
	localparam int unsigned SIDE_W       = 9;
	localparam int unsigned INDEX_W      = 16;
	localparam int unsigned CFG_IDX_W    = 1;

	localparam logic [SIDE_W-1:0] GRID_SIDE_RST   = 9'd20;
	localparam logic [SIDE_W-1:0] SWATH_WIDTH_RST = 9'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIDE   = 1'b0,
		CFG_SWATH_WIDTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [15:0] {
		PH_FWD_UP  = 16'h0001,
		PH_FWD_LO  = 16'h0002,
		PH_DEG_A   = 16'h0004,
		PH_DEG_B   = 16'h0008,
		PH_BWD_UP  = 16'h0010,
		PH_BWD_LO  = 16'h0020,
		PH_JMP_A   = 16'h0040,
		PH_JMP_B   = 16'h0080,
		PH_RS_A    = 16'h0100,
		PH_RS_B    = 16'h0200,
		PH_TAIL_A  = 16'h0400,
		PH_TAIL_B  = 16'h0800,
		PH_R_UP    = 16'h1000,
		PH_R_LO    = 16'h2000,
		PH_R_DA    = 16'h4000,
		PH_R_DB    = 16'h8000
	} phase_t;

	typedef struct packed {
		logic step;
		logic restart;
	} ctrl_t;

	typedef struct packed {
		logic [INDEX_W-1:0] vertex_index;
		logic               last;
	} beat_t;

endpackage

### hw/rtl/gsig_in_stage.sv
// input register stage and step control
module gsig_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	input  logic                 out_ready,
	output gsig_pkg::ctrl_t      ctrl
);

	logic valid_s1;
	logic restart_s1;
	logic step;
	logic accept;

	assign step     = valid_s1 & out_ready;
	assign in_stall = valid_s1 & ~step;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= restart;
		end
	end

	assign ctrl.step    = step;
	assign ctrl.restart = restart_s1;

endmodule

### hw/rtl/gsig_walk.sv
// walk state and index arithmetic for one beat
module gsig_walk #(
	parameter int unsigned MAX_SIDE = gsig_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gsig_pkg::SIDE_W-1:0]   grid_side,
	input  logic [gsig_pkg::SIDE_W-1:0]   swath_width,
	input  gsig_pkg::ctrl_t               ctrl,
	output gsig_pkg::beat_t               beat
);

	logic [8:0]       row_q, col_q, bs_q, be_q;
	gsig_pkg::phase_t phase_q;
	logic             fin_q;

	logic [8:0]       y, x, s, e;
	gsig_pkg::phase_t ph;
	logic             fin;
	logic [8:0]       row_d, col_d, bs_d, be_d;
	gsig_pkg::phase_t ph_d;
	logic             fin_d;

	logic [8:0]       n;
	logic [9:0]       n10, nm1, y1, y2, e1;
	logic [8:0]       ew;
	logic [10:0]      t11;
	logic [8:0]       band_t;
	logic [8:0]       first_end;
	logic [9:0]       mul_r;
	logic [8:0]       mul_c;
	logic             dec;
	logic             pair;
	logic [18:0]      prod;
	logic [15:0]      v;

	always_comb begin
		if (grid_side < 9'd2) begin
			n = 9'd2;
		end else if ({1'b0, grid_side} > 10'(MAX_SIDE)) begin
			n = 9'(MAX_SIDE);
		end else begin
			n = grid_side;
		end
	end

	assign n10 = {1'b0, n};
	assign nm1 = n10 - 10'd1;
	assign ew  = (swath_width < 9'd2) ? 9'd2 : swath_width;
	assign first_end = ({1'b0, swath_width} - 10'd1 > nm1) ? nm1[8:0] : swath_width - 9'd1;

	always_comb begin
		y   = row_q;
		x   = col_q;
		s   = bs_q;
		e   = be_q;
		ph  = phase_q;
		fin = fin_q;
		if (ctrl.restart) begin
			y   = '0;
			x   = '0;
			s   = '0;
			fin = 1'b0;
			if (swath_width < 9'd2) begin
				e  = '0;
				ph = gsig_pkg::PH_R_UP;
			end else begin
				e  = first_end;
				ph = gsig_pkg::PH_FWD_UP;
			end
		end

		y1  = {1'b0, y} + 10'd1;
		y2  = {1'b0, y} + 10'd2;
		e1  = {1'b0, e} + 10'd1;
		t11 = {2'b0, e} + {2'b0, ew} - 11'd1;
		band_t = (t11 > {1'b0, nm1}) ? nm1[8:0] : t11[8:0];

		row_d = y;
		col_d = x;
		bs_d  = s;
		be_d  = e;
		ph_d  = ph;
		fin_d = fin;
		mul_r = '0;
		mul_c = '0;
		dec   = 1'b0;
		pair  = 1'b0;

		if (!fin) begin
			case (ph)
				gsig_pkg::PH_FWD_UP: begin
					mul_r = {1'b0, y};
					mul_c = x;
					ph_d  = gsig_pkg::PH_FWD_LO;
				end
				gsig_pkg::PH_FWD_LO: begin
					mul_r = y1;
					mul_c = x;
					if (x < e) begin
						col_d = x + 9'd1;
						ph_d  = gsig_pkg::PH_FWD_UP;
					end else if (y2 < n10) begin
						ph_d = gsig_pkg::PH_DEG_A;
					end else if (e1 < n10) begin
						ph_d = gsig_pkg::PH_TAIL_A;
					end else begin
						pair = 1'b1;
					end
				end
				gsig_pkg::PH_DEG_A: begin
					mul_r = y1;
					mul_c = e;
					ph_d  = gsig_pkg::PH_DEG_B;
				end
				gsig_pkg::PH_DEG_B: begin
					mul_r = y2;
					mul_c = e;
					col_d = e;
					ph_d  = gsig_pkg::PH_BWD_UP;
				end
				gsig_pkg::PH_BWD_UP: begin
					mul_r = y2;
					mul_c = x;
					ph_d  = gsig_pkg::PH_BWD_LO;
				end
				gsig_pkg::PH_BWD_LO: begin
					mul_r = y1;
					mul_c = x;
					if (x > s) begin
						col_d = x - 9'd1;
						ph_d  = gsig_pkg::PH_BWD_UP;
					end else if (y2 == nm1 && e1 < n10) begin
						ph_d = gsig_pkg::PH_JMP_A;
					end else begin
						ph_d = gsig_pkg::PH_RS_A;
					end
				end
				gsig_pkg::PH_JMP_A: begin
					mul_r = nm1;
					mul_c = s;
					ph_d  = gsig_pkg::PH_JMP_B;
				end
				gsig_pkg::PH_JMP_B: begin
					mul_c = e;
					pair  = 1'b1;
				end
				gsig_pkg::PH_RS_A: begin
					mul_r = y1;
					mul_c = s;
					ph_d  = gsig_pkg::PH_RS_B;
				end
				gsig_pkg::PH_RS_B: begin
					mul_r = y2;
					mul_c = s;
					pair  = 1'b1;
				end
				gsig_pkg::PH_TAIL_A: begin
					mul_r = nm1;
					mul_c = e;
					ph_d  = gsig_pkg::PH_TAIL_B;
				end
				gsig_pkg::PH_TAIL_B: begin
					mul_c = e;
					pair  = 1'b1;
				end
				gsig_pkg::PH_R_UP: begin
					mul_r = {1'b0, y};
					mul_c = x;
					ph_d  = gsig_pkg::PH_R_LO;
				end
				gsig_pkg::PH_R_LO: begin
					mul_r = y1;
					mul_c = x;
					if ({1'b0, x} + 10'd1 < n10) begin
						col_d = x + 9'd1;
						ph_d  = gsig_pkg::PH_R_UP;
					end else if (y2 < n10) begin
						ph_d = gsig_pkg::PH_R_DA;
					end else begin
						fin_d = 1'b1;
					end
				end
				gsig_pkg::PH_R_DA: begin
					mul_r = y2;
					dec   = 1'b1;
					ph_d  = gsig_pkg::PH_R_DB;
				end
				gsig_pkg::PH_R_DB: begin
					mul_r = y1;
					row_d = y1[8:0];
					col_d = '0;
					ph_d  = gsig_pkg::PH_R_UP;
				end
				default: begin
					fin_d = 1'b1;
					ph_d  = gsig_pkg::PH_FWD_UP;
				end
			endcase
		end

		// next row pair, next band once the rows run out, or finish after the last band
		if (pair) begin
			row_d = y2[8:0];
			if (y2 + 10'd1 < n10) begin
				col_d = s;
				ph_d  = gsig_pkg::PH_FWD_UP;
			end else if (e1 >= n10) begin
				fin_d = 1'b1;
			end else begin
				bs_d  = e;
				be_d  = band_t;
				row_d = '0;
				col_d = e;
				ph_d  = gsig_pkg::PH_FWD_UP;
			end
		end
	end

	assign prod = {9'b0, mul_r} * {10'b0, n};
	assign v    = prod[15:0] + {7'b0, mul_c} - {15'b0, dec};

	assign beat.vertex_index = fin ? '0 : v;
	assign beat.last         = fin ? 1'b1 : fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			bs_q    <= '0;
			be_q    <= '0;
			phase_q <= gsig_pkg::PH_FWD_UP;
			fin_q   <= 1'b1;
		end else if (ctrl.step) begin
			row_q   <= row_d;
			col_q   <= col_d;
			bs_q    <= bs_d;
			be_q    <= be_d;
			phase_q <= ph_d;
			fin_q   <= fin_d;
		end
	end

`ifndef ASSERT_OFF
	a_last_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && beat.last) |=> fin_q)
		else $error("last beat did not leave the walk finished");

	a_idle_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && fin_q && !ctrl.restart) |->
		(beat.vertex_index == '0 && beat.last))
		else $error("idle beat carries a non-zero index");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.step |=> ($stable(phase_q) && $stable(row_q) && $stable(col_q)
		&& $stable(fin_q)))
		else $error("walk state moved without a step");

	a_restart_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && ctrl.restart) |-> !beat.last)
		else $error("restart beat marked as last");
`endif

endmodule

### hw/rtl/gsig_out_stage.sv
// result register towards the receiver
module gsig_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  gsig_pkg::beat_t               beat,
	output logic                          out_ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gsig_pkg::INDEX_W-1:0]  vertex_index,
	output logic                          last
);

	logic            valid_q;
	gsig_pkg::beat_t beat_q;

	assign out_ready = ~valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			beat_q <= beat;
		end
	end

	assign out_valid    = valid_q;
	assign vertex_index = beat_q.vertex_index;
	assign last         = beat_q.last;

endmodule

### hw/rtl/grid_strip_index_generator.sv
// top level of the grid strip index generator
// Produces one triangle-strip vertex index per input beat for an N x N grid.
// Input channel: in_valid / in_stall with payload restart; restart=1 begins
// the index list anew, restart=0 asks for the next index.
// Output channel: out_valid / out_stall with vertex_index and last; last is
// high on the final index, and every beat after it gives index 0, last 1,
// until a restart beat arrives.
// Configuration: cfg_write with cfg_index / cfg_data sets grid_side (index 0)
// and swath_width (index 1); write only while no beat is in flight.
// An accepted beat is held in the input register, then in the result register.
// Throughput: one beat per cycle unless the receiver stalls; the walk state, the
// single 10 x 9 multiply and the add of row * side + column are combinational.
// Reset: the walk is finished and waits for restart; grid_side is 20 and
// swath_width is 0 (row mode).
// When the receiver stalls, the result register holds its beat, one more beat
// waits in the input register, and in_stall then rises.
module grid_strip_index_generator #(
	parameter int unsigned MAX_SIDE = gsig_pkg::MAX_SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [gsig_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gsig_pkg::SIDE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gsig_pkg::INDEX_W-1:0]   vertex_index,
	output logic                           last
);

	logic [gsig_pkg::SIDE_W-1:0] grid_side_q;
	logic [gsig_pkg::SIDE_W-1:0] swath_width_q;
	logic                        out_ready;
	gsig_pkg::ctrl_t             ctrl;
	gsig_pkg::beat_t             beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q   <= gsig_pkg::GRID_SIDE_RST;
			swath_width_q <= gsig_pkg::SWATH_WIDTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				gsig_pkg::CFG_GRID_SIDE:   grid_side_q   <= cfg_data;
				gsig_pkg::CFG_SWATH_WIDTH: swath_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gsig_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	gsig_walk #(
		.MAX_SIDE (MAX_SIDE)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_side   (grid_side_q),
		.swath_width (swath_width_q),
		.ctrl        (ctrl),
		.beat        (beat)
	);

	gsig_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (ctrl.step),
		.beat         (beat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.last         (last)
	);

endmodule
